/* rtl/crring_pkg.sv */
// Shared types and constants for the chunked read completion ring.
package crring_pkg;

  localparam int unsigned OFFSET_W = 48;
  localparam int unsigned CHUNK_W  = 17;
  localparam int unsigned ERR_W    = 8;
  localparam int unsigned FIELD_SLOT_W = 3;
  localparam int unsigned RETIRED_W    = 4;
  localparam int unsigned IN_DATA_W    = 32;
  localparam int unsigned OUT_DATA_W   = 112;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam logic [CHUNK_W-1:0] CHUNK_MAX = 17'h10000;
  localparam logic [CHUNK_W-1:0] CHUNK_MIN = 17'h00001;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CHUNK    = 1'b1;

  typedef enum logic [1:0] {
    FN_ISSUE    = 2'd0,
    FN_COMPLETE = 2'd1,
    FN_RETIRE   = 2'd2,
    FN_UNDO     = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ISSUE,
    ST_WALK,
    ST_RETIRE,
    ST_OUT
  } state_t;

endpackage

/* rtl/chunked_read_inorder_completion_ring_top.sv */
// Chunked read completion ring: slot ring with in-order retirement and chunk issue.
//
// Takes one request at a time. A request is accepted, executed and its result held
// on the output until taken; the input is not ready meanwhile. After acceptance a
// request passes through the execute state and goes straight to the output state for
// a complete that retires nothing, a refused issue or retire, and an undo; an
// accepted issue goes through the issue state first and a retire of a slot without
// error through the retire state; a complete of the oldest outstanding slot goes
// through the walk state, which moves slots to done while the oldest outstanding one
// is done. The block is ready again in the cycle after the result is taken. The
// steps are set by the single shared 48-bit add/subtract unit (remaining-length,
// position and remaining-byte updates each take a turn) and by the walk, one slot a cycle.
module chunked_read_inorder_completion_ring_top #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // func[1:0], slot_index[4:2], error_code[12:5], done_length[29:13], zero pad
  input  logic [crring_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // issue_accepted[0], issue_slot[3:1], read_offset[51:4], read_length[68:52],
  // retired_now[72:69], chunk_valid[73], chunk_slot[76:74], chunk_length[93:77],
  // chunk_error[101:94], sticky_error[109:102], finished[110], zero pad
  output logic [crring_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_we,
  input  logic [crring_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crring_pkg::OFFSET_W-1:0]     cfg_data
);
  import crring_pkg::*;

  localparam int unsigned IW = $clog2(SLOT_COUNT);
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned SW = (IW > FIELD_SLOT_W) ? IW : FIELD_SLOT_W;
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOT_COUNT - 1);
  localparam logic [CW-1:0] FULL      = CW'(SLOT_COUNT);

  state_t state, state_next;

  logic [OFFSET_W-1:0] total_length;
  logic [CHUNK_W-1:0]  max_chunk;
  logic [OFFSET_W-1:0] read_position;
  logic [OFFSET_W-1:0] remaining_bytes;
  logic [ERR_W-1:0]    first_error;

  logic                slot_done   [SLOT_COUNT];
  logic [ERR_W-1:0]    slot_error  [SLOT_COUNT];
  logic [CHUNK_W-1:0]  slot_length [SLOT_COUNT];

  logic [IW-1:0] done_head, active_head, free_head;
  logic [CW-1:0] done_total, active_total, free_total;

  func_t               op_func;
  logic [FIELD_SLOT_W-1:0] op_slot;
  logic [ERR_W-1:0]    op_err;
  logic [CHUNK_W-1:0]  op_len;

  logic [OFFSET_W-1:0] left;
  logic [CHUNK_W-1:0]  ret_len;

  logic                    res_issue_ok;
  logic [FIELD_SLOT_W-1:0] res_issue_slot;
  logic [OFFSET_W-1:0]     res_offset;
  logic [CHUNK_W-1:0]      res_len;
  logic [CW-1:0]           res_moved;
  logic                    res_chunk_valid;
  logic [FIELD_SLOT_W-1:0] res_chunk_slot;
  logic [CHUNK_W-1:0]      res_chunk_len;
  logic [ERR_W-1:0]        res_chunk_err;

  // shared add/subtract unit
  logic [OFFSET_W-1:0] alu_a, alu_b;
  logic                alu_sub;
  logic [OFFSET_W:0]   alu_sum;

  logic [SW-1:0]       op_slot_w, active_head_w;
  logic [IW-1:0]       op_idx;
  logic                issue_ok, complete_ok, walk_start, retire_ok, undo_ok, walk_step;
  logic [CHUNK_W-1:0]  issue_len;
  logic [CHUNK_W-1:0]  cfg_chunk;
  logic                in_fire;
  logic [CW+3:0]       moved_ext;
  logic [IW+2:0]       free_head_ext, done_head_ext;

  assign in_fire = s_tvalid && s_tready;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      ST_EXEC: begin
        alu_a   = total_length;
        alu_b   = read_position;
        alu_sub = 1'b1;
      end
      ST_ISSUE: begin
        alu_a = read_position;
        alu_b = OFFSET_W'(issue_len);
      end
      ST_RETIRE: begin
        alu_a   = remaining_bytes;
        alu_b   = OFFSET_W'(ret_len);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {OFFSET_W{alu_sub}}}
                 + (OFFSET_W + 1)'(alu_sub);

  assign issue_len = ((left[OFFSET_W-1:CHUNK_W] != '0) || (left[CHUNK_W-1:0] >= max_chunk))
                   ? max_chunk : left[CHUNK_W-1:0];

  assign op_slot_w     = SW'(op_slot);
  assign active_head_w = SW'(active_head);
  assign op_idx        = op_slot_w[IW-1:0];

  assign issue_ok    = alu_sum[OFFSET_W] && (alu_sum[OFFSET_W-1:0] != '0) && (free_total != '0);
  assign complete_ok = 32'(op_slot) < SLOT_COUNT;
  assign walk_start  = complete_ok && (op_slot_w == active_head_w);
  assign retire_ok   = (remaining_bytes != '0) && (done_total != '0);
  assign undo_ok     = (active_total != '0) && (free_total < FULL);
  assign walk_step   = (active_total != '0) && slot_done[active_head];

  always_comb begin
    cfg_chunk = cfg_data[CHUNK_W-1:0];
    if (cfg_chunk == '0) begin
      cfg_chunk = CHUNK_MIN;
    end else if (cfg_chunk > CHUNK_MAX) begin
      cfg_chunk = CHUNK_MAX;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (op_func)
          FN_ISSUE:    state_next = issue_ok ? ST_ISSUE : ST_OUT;
          FN_COMPLETE: state_next = walk_start ? ST_WALK : ST_OUT;
          FN_RETIRE: begin
            state_next = (retire_ok && (slot_error[done_head] == '0)) ? ST_RETIRE : ST_OUT;
          end
          default:     state_next = ST_OUT;
        endcase
      end
      ST_ISSUE:  state_next = ST_OUT;
      ST_WALK:   state_next = walk_step ? ST_WALK : ST_OUT;
      ST_RETIRE: state_next = ST_OUT;
      ST_OUT: begin
        if (m_tready) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_OUT:  m_tvalid = 1'b1;
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_func    <= func_t'(s_tdata[1:0]);
      op_slot    <= s_tdata[4:2];
      op_err     <= s_tdata[12:5];
      op_len     <= s_tdata[29:13];
      res_offset <= '0;
      res_len    <= '0;
    end
    if ((state == ST_EXEC) && (op_func == FN_ISSUE)) begin
      left <= alu_sum[OFFSET_W-1:0];
    end
    if ((state == ST_EXEC) && (op_func == FN_RETIRE)) begin
      ret_len <= slot_length[done_head];
    end
    if ((state == ST_EXEC) && (op_func == FN_COMPLETE) && complete_ok && (op_err == '0)) begin
      slot_length[op_idx] <= op_len;
    end
    if (state == ST_ISSUE) begin
      res_offset <= read_position;
      res_len    <= issue_len;
    end
  end

  assign free_head_ext = {3'b000, free_head};
  assign done_head_ext = {3'b000, done_head};

  always_ff @(posedge clk) begin
    if (rst) begin
      total_length    <= '0;
      max_chunk       <= CHUNK_MAX;
      read_position   <= '0;
      remaining_bytes <= '0;
      first_error     <= '0;
      done_head       <= '0;
      active_head     <= '0;
      free_head       <= '0;
      done_total      <= '0;
      active_total    <= '0;
      free_total      <= FULL;
      res_issue_ok    <= 1'b0;
      res_issue_slot  <= '0;
      res_moved       <= '0;
      res_chunk_valid <= 1'b0;
      res_chunk_slot  <= '0;
      res_chunk_len   <= '0;
      res_chunk_err   <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_done[i]  <= 1'b0;
        slot_error[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TOTAL_LENGTH: begin
            total_length    <= cfg_data;
            remaining_bytes <= cfg_data;
            read_position   <= '0;
          end
          REG_MAX_CHUNK: max_chunk <= cfg_chunk;
          default: max_chunk <= max_chunk;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            res_issue_ok    <= 1'b0;
            res_issue_slot  <= '0;
            res_moved       <= '0;
            res_chunk_valid <= 1'b0;
            res_chunk_slot  <= '0;
            res_chunk_len   <= '0;
            res_chunk_err   <= '0;
          end
        end
        ST_EXEC: begin
          case (op_func)
            FN_COMPLETE: begin
              if (complete_ok) begin
                slot_error[op_idx] <= op_err;
                slot_done[op_idx]  <= 1'b1;
                if ((op_err != '0) && (first_error == '0)) first_error <= op_err;
              end
            end
            FN_RETIRE: begin
              if (retire_ok) begin
                done_head       <= (done_head == LAST_SLOT) ? '0 : done_head + 1'b1;
                done_total      <= done_total - 1'b1;
                free_total      <= free_total + 1'b1;
                res_chunk_valid <= 1'b1;
                res_chunk_slot  <= done_head_ext[2:0];
                res_chunk_err   <= slot_error[done_head];
              end
            end
            FN_UNDO: begin
              if (undo_ok) begin
                free_head    <= (free_head == '0) ? LAST_SLOT : free_head - 1'b1;
                free_total   <= free_total + 1'b1;
                active_total <= active_total - 1'b1;
              end
            end
            default: begin
              res_issue_ok <= 1'b0;
            end
          endcase
        end
        ST_ISSUE: begin
          slot_done[free_head] <= 1'b0;
          free_head      <= (free_head == LAST_SLOT) ? '0 : free_head + 1'b1;
          free_total     <= free_total - 1'b1;
          active_total   <= active_total + 1'b1;
          read_position  <= alu_sum[OFFSET_W-1:0];
          res_issue_ok   <= 1'b1;
          res_issue_slot <= free_head_ext[2:0];
        end
        ST_WALK: begin
          if (walk_step) begin
            active_head  <= (active_head == LAST_SLOT) ? '0 : active_head + 1'b1;
            active_total <= active_total - 1'b1;
            done_total   <= done_total + 1'b1;
            res_moved    <= res_moved + 1'b1;
          end
        end
        ST_RETIRE: begin
          remaining_bytes <= alu_sum[OFFSET_W] ? alu_sum[OFFSET_W-1:0] : '0;
          res_chunk_len   <= ret_len;
        end
        default: begin
          res_moved <= res_moved;
        end
      endcase
    end
  end

  assign moved_ext = {4'b0000, res_moved};

  assign m_tdata = {1'b0, (remaining_bytes == '0), first_error, res_chunk_err, res_chunk_len,
                    res_chunk_slot, res_chunk_valid, moved_ext[RETIRED_W-1:0], res_len,
                    res_offset, res_issue_slot, res_issue_ok};

`ifndef SYNTH
  a_slot_conservation: assert property (@(posedge clk) disable iff (rst)
    ((CW+2)'(free_total) + (CW+2)'(active_total) + (CW+2)'(done_total))
      == (CW+2)'(SLOT_COUNT))
    else $error("slot region totals do not add up to the ring size");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("request accepted while a result is pending");

  a_return_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |=> s_tready)
    else $error("not ready after result was taken");

  a_walk_moves: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_WALK) && walk_step) |=> (done_total == $past(done_total) + 1'b1))
    else $error("walk step did not move a slot to done");
`endif

endmodule
